### hdl/cdns_pkg.sv
// Shared types, codes and constants of the captive DNS A-record responder.
`default_nettype none

package cdns_pkg;

    // Depth of the command queue between the parser and the reply generator.
    localparam int QUEUE_DEPTH = 4;

    // Frame layout.
    localparam int POS_FLAGS_HI   = 2;
    localparam int POS_FLAGS_LO   = 3;
    localparam int POS_QDCOUNT_HI = 4;
    localparam int POS_QDCOUNT_LO = 5;
    localparam int POS_ANCOUNT_HI = 6;
    localparam int POS_ANCOUNT_LO = 7;
    localparam int HEADER_LAST    = 11;
    localparam int MIN_FRAME      = 13;
    localparam int MAX_LABEL      = 63;
    localparam int ANSWER_BYTES   = 16;
    localparam int QUESTION_TAIL  = 4;

    // Header values.
    localparam logic [15:0] REPLY_FLAGS   = 16'h8000;
    localparam logic [15:0] QUERY_MASK    = 16'h7800;
    localparam logic [15:0] QDCOUNT_ONE   = 16'h0001;
    localparam logic [15:0] ANCOUNT_ONE   = 16'h0001;
    localparam logic [31:0] TYPE_CLASS_OK = 32'h0001_0001;

    // Answer record fields.
    localparam logic [15:0] ANS_NAME_PTR = 16'hC00C;
    localparam logic [15:0] ANS_TYPE     = 16'h0001;
    localparam logic [15:0] ANS_CLASS    = 16'h0001;
    localparam logic [31:0] ANS_TTL      = 32'd300;
    localparam logic [15:0] ANS_RDLENGTH = 16'd4;

    // Status reported on the final result of a frame.
    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_SHORT          = 3'd1,
        ST_NOT_QUERY      = 3'd2,
        ST_BAD_LABEL      = 3'd3,
        ST_UNTERMINATED   = 3'd4,
        ST_QUESTION_SHORT = 3'd5,
        ST_NOT_A_IN       = 3'd6,
        ST_TOO_LARGE      = 3'd7
    } t_status;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_HEADER   = 5'b00001,
        PH_LEN      = 5'b00010,
        PH_LABEL    = 5'b00100,
        PH_QUESTION = 5'b01000,
        PH_DONE     = 5'b10000
    } t_phase;

    // Command handed from the parser to the reply generator.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_cmd;

    // Byte of the appended A answer record at the given index.
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] addr);
        logic [7:0] b;
        case (idx)
            4'd0:    b = ANS_NAME_PTR[15:8];
            4'd1:    b = ANS_NAME_PTR[7:0];
            4'd2:    b = ANS_TYPE[15:8];
            4'd3:    b = ANS_TYPE[7:0];
            4'd4:    b = ANS_CLASS[15:8];
            4'd5:    b = ANS_CLASS[7:0];
            4'd6:    b = ANS_TTL[31:24];
            4'd7:    b = ANS_TTL[23:16];
            4'd8:    b = ANS_TTL[15:8];
            4'd9:    b = ANS_TTL[7:0];
            4'd10:   b = ANS_RDLENGTH[15:8];
            4'd11:   b = ANS_RDLENGTH[7:0];
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            default: b = addr[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### hdl/cdns_front.sv
// Query parser: classifies each accepted byte and issues reply commands.
`default_nettype none

module cdns_front #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_in_last,
    output logic               o_push,
    output cdns_pkg::t_cmd     o_cmd
);
    import cdns_pkg::*;

    localparam int PW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = PW + 1;
    localparam logic [PW-1:0] BUF_LIMIT = PW'(BUFFER_BYTES);

    logic [PW-1:0] r_pos, n_pos;
    t_phase        r_phase, n_phase;
    t_status       r_err, n_err;
    logic [5:0]    r_left, n_left;
    logic [1:0]    r_qseen, n_qseen;
    logic [7:0]    r_flags_hi, n_flags_hi;
    logic [7:0]    r_qd_hi, n_qd_hi;
    logic [23:0]   r_tc, n_tc;

    logic          emit;
    logic [7:0]    ob;
    t_status       st;
    logic [SW-1:0] answer_end;

    assign answer_end = {1'b0, r_pos} + SW'(ANSWER_BYTES + 1);

    // Parse one byte and work out the frame status if it is the last.
    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_err      = r_err;
        n_left     = r_left;
        n_qseen    = r_qseen;
        n_flags_hi = r_flags_hi;
        n_qd_hi    = r_qd_hi;
        n_tc       = r_tc;
        emit       = 1'b0;
        ob         = i_in_byte;
        st         = ST_OK;

        if (i_accept && (r_pos < BUF_LIMIT)) begin
            n_pos = r_pos + 1'b1;
            if (r_err == ST_OK) begin
                case (r_phase)
                    PH_HEADER: begin
                        emit = 1'b1;
                        if (r_pos == PW'(POS_FLAGS_HI)) begin
                            n_flags_hi = i_in_byte;
                            ob         = REPLY_FLAGS[15:8];
                        end else if (r_pos == PW'(POS_FLAGS_LO)) begin
                            ob = REPLY_FLAGS[7:0];
                            if (r_flags_hi[7] ||
                                (({r_flags_hi, i_in_byte} & QUERY_MASK) != 16'h0000)) begin
                                n_err = ST_NOT_QUERY;
                                emit  = 1'b0;
                            end
                        end else if (r_pos == PW'(POS_QDCOUNT_HI)) begin
                            n_qd_hi = i_in_byte;
                        end else if (r_pos == PW'(POS_QDCOUNT_LO)) begin
                            if ({r_qd_hi, i_in_byte} != QDCOUNT_ONE) begin
                                n_err = ST_NOT_QUERY;
                                emit  = 1'b0;
                            end
                        end else if (r_pos == PW'(POS_ANCOUNT_HI)) begin
                            ob = ANCOUNT_ONE[15:8];
                        end else if (r_pos == PW'(POS_ANCOUNT_LO)) begin
                            ob = ANCOUNT_ONE[7:0];
                        end
                        if (r_pos >= PW'(HEADER_LAST)) begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        emit = 1'b1;
                        if (i_in_byte == 8'd0) begin
                            n_phase = PH_QUESTION;
                            n_qseen = 2'd0;
                        end else if (i_in_byte > 8'(MAX_LABEL)) begin
                            n_err = ST_BAD_LABEL;
                            emit  = 1'b0;
                        end else begin
                            n_left  = i_in_byte[5:0];
                            n_phase = PH_LABEL;
                        end
                    end
                    PH_LABEL: begin
                        emit   = 1'b1;
                        n_left = r_left - 1'b1;
                        if (n_left == 6'd0) begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_QUESTION: begin
                        emit    = 1'b1;
                        n_tc    = {r_tc[15:0], i_in_byte};
                        n_qseen = r_qseen + 1'b1;
                        if (r_qseen == 2'(QUESTION_TAIL - 1)) begin
                            n_phase = PH_DONE;
                            if ({r_tc, i_in_byte} != TYPE_CLASS_OK) begin
                                n_err = ST_NOT_A_IN;
                                emit  = 1'b0;
                            end else if (answer_end > SW'(BUFFER_BYTES)) begin
                                n_err = ST_TOO_LARGE;
                                emit  = 1'b0;
                            end
                        end
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
        end

        // Final status, short frames taking precedence over every other error.
        if (n_pos < PW'(MIN_FRAME)) begin
            st = ST_SHORT;
        end else if (n_err != ST_OK) begin
            st = n_err;
        end else if ((n_phase == PH_LEN) || (n_phase == PH_LABEL)) begin
            st = ST_UNTERMINATED;
        end else if (n_phase == PH_QUESTION) begin
            st = ST_QUESTION_SHORT;
        end

        // The last byte closes the frame and returns the parser to its start.
        if (i_accept && i_in_last) begin
            n_pos   = '0;
            n_phase = PH_HEADER;
            n_err   = ST_OK;
            n_left  = 6'd0;
            n_qseen = 2'd0;
        end
    end

    // Command towards the reply generator.
    always_comb begin
        o_cmd.has_byte = emit && (!i_in_last || (st == ST_OK));
        o_cmd.data     = ob;
        o_cmd.last     = i_in_last;
        o_cmd.status   = i_in_last ? st : ST_OK;
        o_push         = i_accept && (emit || i_in_last);
    end

    // Parser control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_err   <= ST_OK;
            r_left  <= 6'd0;
            r_qseen <= 2'd0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_err   <= n_err;
            r_left  <= n_left;
            r_qseen <= n_qseen;
        end
    end

    // Captured header and question fields.
    always_ff @(posedge i_clk) begin
        r_flags_hi <= n_flags_hi;
        r_qd_hi    <= n_qd_hi;
        r_tc       <= n_tc;
    end

endmodule

`default_nettype wire

### hdl/cdns_fifo.sv
// Short command queue between the parser and the reply generator.
`default_nettype none

module cdns_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cdns_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output cdns_pkg::t_cmd      o_cmd,
    output logic                o_full,
    output logic                o_empty
);
    import cdns_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### hdl/cdns_back.sv
// Reply generator: turns queued commands into result bytes and the answer tail.
`default_nettype none

module cdns_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cdns_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    input  wire logic [31:0]    i_server_address,
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic [7:0]          o_byte,
    output logic                o_last,
    output logic [2:0]          o_status
);
    import cdns_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    t_status    r_out_status;

    logic       advance;
    logic       load;
    logic [7:0] step_byte;
    logic       step_last;
    t_status    step_status;
    logic       step_done;

    // One result is produced whenever a command is held and the output register is free or drained.
    assign advance   = r_busy && (!r_out_valid || i_pop);
    assign load      = !r_busy || (advance && step_done);
    assign o_cmd_pop = load && !i_cmd_empty;

    // Result selected by the current command.
    always_comb begin
        if (r_cmd.has_byte) begin
            step_byte   = r_cmd.data;
            step_last   = 1'b0;
            step_status = ST_OK;
            step_done   = !r_cmd.last;
        end else if (r_cmd.status != ST_OK) begin
            step_byte   = 8'h00;
            step_last   = 1'b1;
            step_status = r_cmd.status;
            step_done   = 1'b1;
        end else begin
            step_byte   = answer_byte(r_idx, i_server_address);
            step_last   = (r_idx == 4'(ANSWER_BYTES - 1));
            step_status = ST_OK;
            step_done   = step_last;
        end
    end

    // Command register and answer counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= !i_cmd_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
            r_idx <= 4'd0;
        end else if (advance) begin
            if (r_cmd.has_byte) begin
                r_cmd.has_byte <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte   <= step_byte;
            r_out_last   <= step_last;
            r_out_status <= step_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_last   = r_out_last;
    assign o_status = r_out_status;

endmodule

`default_nettype wire

### hdl/captive_dns_a_responder.sv
// Top level of the captive DNS A-record responder.
// A result passes through the command queue, the command register and the output register of the reply generator.
// Throughput: one byte per cycle while the queue is not full and results are taken; the last byte of a
// good frame adds the sixteen-byte answer record, stepped by the answer counter of the reply generator.
// The command queue holds four commands, so input stalls once it is full.
// Reset is synchronous, active low: frame state and queue clear, address is 0.
`default_nettype none

module captive_dns_a_responder #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic [2:0]       o_status,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [31:0] i_server_address
);
    import cdns_pkg::*;

    logic [31:0] r_server_address;
    logic        accept;
    logic        q_push, q_pop, q_full, q_empty;
    t_cmd        q_in, q_out;
    logic        out_valid;

    assign ready  = 1'b1;
    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    // Server address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_address <= 32'd0;
        end else if (valid && ready) begin
            r_server_address <= i_server_address;
        end
    end

    cdns_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    cdns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cdns_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (q_out),
        .i_cmd_empty      (q_empty),
        .o_cmd_pop        (q_pop),
        .i_server_address (r_server_address),
        .i_pop            (pop),
        .o_valid          (out_valid),
        .o_byte           (o_out_byte),
        .o_last           (o_out_last),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire

### hdl/cdns_checker.sv
// Port-level assertions for the responder and their attachment to the top level.
`default_nettype none

module cdns_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_out_last,
    input wire logic [2:0]  o_status
);
    import cdns_pkg::*;

    // After reset no result is waiting and input is open.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("result or full flag present after reset");

    // A waiting result that is not taken stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_out_last)
                              && $stable(o_status)))
        else $error("waiting result changed before it was taken");

    // An error status only appears on a closing result whose byte is zero.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != ST_OK)) |-> (o_out_last && (o_out_byte == 8'd0)))
        else $error("error status on a malformed result");

    // Results inside a frame carry no status.
    a_mid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_last) |-> (o_status == ST_OK))
        else $error("status set on a result that does not close the frame");

endmodule

bind captive_dns_a_responder cdns_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_out_last (o_out_last),
    .o_status   (o_status)
);

`default_nettype wire
